FILE: sv/bvcr_pkg.sv
`timescale 1ns / 1ps
package bvcr_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int OUT_BITS       = 24;
  // extents at or above 2^25 always saturate the radius
  localparam int DIFF_BITS      = 25;
  localparam int PROD_BITS      = 2 * DIFF_BITS;
  localparam int SUM_BITS       = PROD_BITS + 2;
  localparam int ROOT_BITS      = SUM_BITS / 2;
  localparam int REM_BITS       = ROOT_BITS + 2;
  localparam int ITER_BITS      = $clog2(ROOT_BITS);
  localparam int QUEUE_DEPTH    = 2;

endpackage

FILE: sv/bvcr_fifo.sv
`timescale 1ns / 1ps
module bvcr_fifo #(
  parameter int WIDTH = 144,
  parameter int DEPTH = bvcr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: sv/bvcr_front.sv
`timescale 1ns / 1ps
module bvcr_front #(
  parameter int COORD_BITS = bvcr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic signed [COORD_BITS-1:0] x_coord,
  input  logic signed [COORD_BITS-1:0] y_coord,
  input  logic signed [COORD_BITS-1:0] z_coord,
  input  logic                         last_vertex,
  output logic                         q_push,
  output logic [6*COORD_BITS-1:0]      q_data
);

  localparam logic signed [COORD_BITS-1:0] POS_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] NEG_MAX = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [COORD_BITS-1:0] min_x, max_x, min_y, max_y, min_z, max_z;
  logic signed [COORD_BITS-1:0] min_x_next, max_x_next, min_y_next, max_y_next;
  logic signed [COORD_BITS-1:0] min_z_next, max_z_next;

  always_comb begin
    min_x_next = (x_coord < min_x) ? x_coord : min_x;
    max_x_next = (x_coord > max_x) ? x_coord : max_x;
    min_y_next = (y_coord < min_y) ? y_coord : min_y;
    max_y_next = (y_coord > max_y) ? y_coord : max_y;
    min_z_next = (z_coord < min_z) ? z_coord : min_z;
    max_z_next = (z_coord > max_z) ? z_coord : max_z;
  end

  assign q_push = accept && last_vertex;
  assign q_data = {min_x_next, max_x_next, min_y_next, max_y_next, min_z_next, max_z_next};

  always_ff @(posedge clk) begin
    if (rst || q_push) begin
      min_x <= POS_MAX;
      min_y <= POS_MAX;
      min_z <= POS_MAX;
      max_x <= NEG_MAX;
      max_y <= NEG_MAX;
      max_z <= NEG_MAX;
    end else if (accept) begin
      min_x <= min_x_next;
      min_y <= min_y_next;
      min_z <= min_z_next;
      max_x <= max_x_next;
      max_y <= max_y_next;
      max_z <= max_z_next;
    end
  end

endmodule

FILE: sv/bvcr_back.sv
`timescale 1ns / 1ps
module bvcr_back #(
  parameter int COORD_BITS = bvcr_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  input  logic [6*COORD_BITS-1:0]              q_data,
  output logic                                 q_pop,
  input  logic                                 pop,
  output logic                                 empty,
  output logic signed [bvcr_pkg::OUT_BITS-1:0] center_x,
  output logic signed [bvcr_pkg::OUT_BITS-1:0] center_y,
  output logic signed [bvcr_pkg::OUT_BITS-1:0] center_z,
  output logic [bvcr_pkg::OUT_BITS-1:0]        radius
);

  localparam int OB = bvcr_pkg::OUT_BITS;
  localparam int DB = bvcr_pkg::DIFF_BITS;
  localparam int PB = bvcr_pkg::PROD_BITS;
  localparam int SB = bvcr_pkg::SUM_BITS;
  localparam int RB = bvcr_pkg::ROOT_BITS;
  localparam int MB = bvcr_pkg::REM_BITS;
  localparam int IB = bvcr_pkg::ITER_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ROOT = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;

  logic signed [COORD_BITS-1:0] lo [3];
  logic signed [COORD_BITS-1:0] hi [3];
  logic [COORD_BITS:0]          diff_a [3];
  logic [COORD_BITS:0]          sum_a [3];
  logic [32:0]                  dext [3];
  logic signed [32:0]           cext [3];
  logic [DB-1:0]                d_new [3];
  logic [2:0]                   sat_a;

  logic [DB-1:0]         d [3];
  logic                  sat;
  logic signed [OB-1:0]  cen [3];
  logic [1:0]            cnt;
  logic [DB-1:0]         d_sel;
  logic [PB-1:0]         prod;
  logic [SB-1:0]         acc;
  logic [SB-1:0]         n;
  logic [MB-1:0]         rem;
  logic [RB-1:0]         root;
  logic [IB-1:0]         iter;
  logic                  out_valid;
  logic                  out_load;

  logic [MB-1:0] rem_sh;
  logic [MB-1:0] trial;
  logic          ge;

  always_comb begin
    lo[0] = q_data[6*COORD_BITS-1 -: COORD_BITS];
    hi[0] = q_data[5*COORD_BITS-1 -: COORD_BITS];
    lo[1] = q_data[4*COORD_BITS-1 -: COORD_BITS];
    hi[1] = q_data[3*COORD_BITS-1 -: COORD_BITS];
    lo[2] = q_data[2*COORD_BITS-1 -: COORD_BITS];
    hi[2] = q_data[COORD_BITS-1 -: COORD_BITS];
    for (int a = 0; a < 3; a++) begin
      diff_a[a] = {hi[a][COORD_BITS-1], hi[a]} - {lo[a][COORD_BITS-1], lo[a]};
      sum_a[a]  = {hi[a][COORD_BITS-1], hi[a]} + {lo[a][COORD_BITS-1], lo[a]};
      dext[a]   = 33'(diff_a[a]);
      cext[a]   = 33'($signed(sum_a[a][COORD_BITS:1]));
      sat_a[a]  = |dext[a][32:DB];
      d_new[a]  = dext[a][DB-1:0];
    end
  end

  always_comb begin
    case (cnt)
      2'd0:    d_sel = d[0];
      2'd1:    d_sel = d[1];
      default: d_sel = d[2];
    endcase
  end

  // one result bit per step
  always_comb begin
    rem_sh = {rem[MB-3:0], n[SB-1:SB-2]};
    trial  = {root, 2'b01};
    ge     = (rem_sh >= trial);
  end

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_load = (state == S_FIN) && (!out_valid || pop);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt == 2'd3) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (iter == IB'(RB - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cnt <= '0;
        acc <= '0;
        if (!q_empty) begin
          sat <= |sat_a;
          for (int a = 0; a < 3; a++) begin
            d[a]   <= d_new[a];
            cen[a] <= cext[a][OB-1:0];
          end
        end
      end
      S_MUL: begin
        cnt <= cnt + 1'b1;
        if (cnt != 2'd3) begin
          prod <= d_sel * d_sel;
        end
        if (cnt != 2'd0) begin
          acc <= acc + SB'(prod);
        end
        if (cnt == 2'd3) begin
          n    <= acc + SB'(prod);
          rem  <= '0;
          root <= '0;
          iter <= '0;
        end
      end
      S_ROOT: begin
        n    <= {n[SB-3:0], 2'b00};
        rem  <= ge ? rem_sh - trial : rem_sh;
        root <= {root[RB-2:0], ge};
        iter <= iter + 1'b1;
      end
      S_FIN: begin
        if (out_load) begin
          center_x <= cen[0];
          center_y <= cen[1];
          center_z <= cen[2];
          radius   <= (sat || root[RB-1]) ? {OB{1'b1}} : root[OB:1];
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

FILE: sv/vertex_bounds_center_radius_core.sv
`timescale 1ns / 1ps
// The last vertex of a set passes through the queue, load, squares, square root and output
// register before its result is on the ports, with the result side free.
// Throughput: one vertex per cycle while the queue has room; set results are computed one at
// a time: load, squares summed, square root at one bit per cycle, then output.
// A two-entry queue holds finished extremes so vertices keep flowing meanwhile.
// Reset (synchronous, rst high): extremes cleared, queue and result empty.
module vertex_bounds_center_radius_core #(
  parameter int COORD_BITS = bvcr_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [COORD_BITS-1:0]         x_coord,
  input  logic signed [COORD_BITS-1:0]         y_coord,
  input  logic signed [COORD_BITS-1:0]         z_coord,
  input  logic                                 last_vertex,
  input  logic                                 pop,
  output logic                                 empty,
  output logic signed [bvcr_pkg::OUT_BITS-1:0] center_x,
  output logic signed [bvcr_pkg::OUT_BITS-1:0] center_y,
  output logic signed [bvcr_pkg::OUT_BITS-1:0] center_z,
  output logic [bvcr_pkg::OUT_BITS-1:0]        radius
);

  logic                      accept;
  logic                      q_push;
  logic [6*COORD_BITS-1:0]   q_wdata;
  logic [6*COORD_BITS-1:0]   q_rdata;
  logic                      q_full;
  logic                      q_empty;
  logic                      q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  bvcr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .z_coord     (z_coord),
    .last_vertex (last_vertex),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  bvcr_fifo #(
    .WIDTH (6 * COORD_BITS),
    .DEPTH (bvcr_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  bvcr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .center_x (center_x),
    .center_y (center_y),
    .center_z (center_z),
    .radius   (radius)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int CW       = bvcr_pkg::COORD_BITS_DEF;
  localparam int OUT_BITS = bvcr_pkg::OUT_BITS;
  localparam int N_RANDOM = 950;
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [OUT_BITS-1:0]  R_SAT = {OUT_BITS{1'b1}};

  typedef struct packed {
    logic signed [OUT_BITS-1:0] cx;
    logic signed [OUT_BITS-1:0] cy;
    logic signed [OUT_BITS-1:0] cz;
    logic [OUT_BITS-1:0]        r;
  } box_t;

  class box_scoreboard;
    logic signed [CW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    box_t expected_boxes[$];
    int mismatches;

    function new();
      mismatches = 0;
      clear_extremes();
    endfunction

    function void clear_extremes();
      lo_x = C_MAX; lo_y = C_MAX; lo_z = C_MAX;
      hi_x = C_MIN; hi_y = C_MIN; hi_z = C_MIN;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, step;
      root = 0;
      step = 64'd1 << 62;
      while (step > n) step >>= 2;
      while (step != 0) begin
        if (n >= root + step) begin
          n -= root + step;
          root = (root >> 1) + step;
        end else begin
          root >>= 1;
        end
        step >>= 2;
      end
      return root;
    endfunction

    // floor((lo + hi) / 2)
    function logic signed [OUT_BITS-1:0] mid(logic signed [CW-1:0] lo, logic signed [CW-1:0] hi);
      longint s;
      s = longint'(lo) + longint'(hi);
      return OUT_BITS'(s >>> 1);
    endfunction

    function void note_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                              logic signed [CW-1:0] z, logic last);
      longint unsigned dx, dy, dz, root;
      box_t b;
      if (x < lo_x) lo_x = x;
      if (x > hi_x) hi_x = x;
      if (y < lo_y) lo_y = y;
      if (y > hi_y) hi_y = y;
      if (z < lo_z) lo_z = z;
      if (z > hi_z) hi_z = z;
      if (!last) return;
      b.cx = mid(lo_x, hi_x);
      b.cy = mid(lo_y, hi_y);
      b.cz = mid(lo_z, hi_z);
      dx = longint'(hi_x) - longint'(lo_x);
      dy = longint'(hi_y) - longint'(lo_y);
      dz = longint'(hi_z) - longint'(lo_z);
      if (dx >= (64'd1 << 25) || dy >= (64'd1 << 25) || dz >= (64'd1 << 25)) begin
        b.r = R_SAT;
      end else begin
        root = int_sqrt(dx * dx + dy * dy + dz * dz) >> 1;
        b.r = (root > R_SAT) ? R_SAT : OUT_BITS'(root);
      end
      expected_boxes.insert(expected_boxes.size(), b);
      clear_extremes();
    endfunction

    function void check_result(box_t got);
      box_t want;
      if (expected_boxes.size() == 0) begin
        $error("result with nothing expected: cx=%0d cy=%0d cz=%0d r=%0d",
               got.cx, got.cy, got.cz, got.r);
        mismatches++;
        return;
      end
      want = expected_boxes.pop_front();
      if (got.cx !== want.cx) begin
        $error("center_x: expected %0d, got %0d", want.cx, got.cx);
        mismatches++;
      end
      if (got.cy !== want.cy) begin
        $error("center_y: expected %0d, got %0d", want.cy, got.cy);
        mismatches++;
      end
      if (got.cz !== want.cz) begin
        $error("center_z: expected %0d, got %0d", want.cz, got.cz);
        mismatches++;
      end
      if (got.r !== want.r) begin
        $error("radius: expected %0d, got %0d", want.r, got.r);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_boxes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic last_vertex = 1'b0;
  logic signed [CW-1:0] x_coord = '0;
  logic signed [CW-1:0] y_coord = '0;
  logic signed [CW-1:0] z_coord = '0;
  logic full, empty;
  logic signed [OUT_BITS-1:0] center_x, center_y, center_z;
  logic [OUT_BITS-1:0] radius;

  box_scoreboard sb = new();
  int n_sent = 0;
  int tx_left = 0;
  int rx_left = 0;
  int rx_wait = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  vertex_bounds_center_radius_core u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .x_coord(x_coord),
    .y_coord(y_coord),
    .z_coord(z_coord),
    .last_vertex(last_vertex),
    .pop(pop),
    .empty(empty),
    .center_x(center_x),
    .center_y(center_y),
    .center_z(center_z),
    .radius(radius)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_vertex(x_coord, y_coord, z_coord, last_vertex);
      if (pop && !empty) sb.check_result('{center_x, center_y, center_z, radius});
    end
  end

  // mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_calm = ($urandom_range(0, 3) == 0);
      rx_left = $urandom_range(100, 400);
    end else begin
      rx_left--;
    end
    if (rx_wait > 0) begin
      pop = 1'b0;
      rx_wait--;
    end else if (!rx_calm && $urandom_range(0, 9) < 3) begin
      pop = 1'b0;
      rx_wait = gap_len() - 1;
    end else begin
      pop = 1'b1;
    end
  end

  task automatic send_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic signed [CW-1:0] z, input logic last);
    int gap;
    gap = 0;
    if (tx_left == 0) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      tx_left = $urandom_range(50, 200);
    end else begin
      tx_left--;
    end
    if (!tx_calm && $urandom_range(0, 9) < 3) gap = gap_len();
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    x_coord = x;
    y_coord = y;
    z_coord = z;
    last_vertex = last;
    push = 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic signed [CW-1:0] pick_coord(logic signed [CW-1:0] base);
    case ($urandom_range(0, 15))
      0:          return C_MAX;
      1:          return C_MIN;
      2, 3, 4, 5: return CW'($urandom());
      default:    return base + CW'(int'($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  initial begin
    int len, r;
    bit paused;
    logic signed [CW-1:0] bx, by, bz;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single-vertex sets
    send_vertex('0, '0, '0, 1'b1);
    send_vertex(C_MAX, C_MAX, C_MAX, 1'b1);
    send_vertex(C_MIN, C_MIN, C_MIN, 1'b1);
    send_vertex(-CW'(256), CW'(256), CW'(128), 1'b1);
    // full extent on every axis, then on x and y only
    send_vertex(C_MIN, C_MIN, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MAX, C_MAX, 1'b1);
    send_vertex(C_MAX, C_MIN, '0, 1'b0);
    send_vertex(C_MIN, C_MAX, -CW'(1), 1'b1);
    // odd sums, negative halves; then a set with even sums
    send_vertex(-CW'(1), -CW'(3), CW'(5), 1'b0);
    send_vertex('0, CW'(2), -CW'(6), 1'b1);
    send_vertex(CW'(1), CW'(1), CW'(1), 1'b0);
    send_vertex(CW'(3), CW'(3), CW'(3), 1'b0);
    send_vertex(CW'(2), CW'(2), CW'(2), 1'b1);
    // repeated vertex, then a symmetric pair
    send_vertex(C_MAX, '0, C_MIN, 1'b0);
    send_vertex(C_MAX, '0, C_MIN, 1'b1);
    send_vertex(CW'(100), -CW'(100), CW'(50), 1'b0);
    send_vertex(-CW'(100), CW'(100), -CW'(50), 1'b1);

    while (n_sent < N_RANDOM) begin
      r = $urandom_range(0, 99);
      if (r < 50) len = $urandom_range(1, 4);
      else if (r < 85) len = $urandom_range(5, 16);
      else len = $urandom_range(17, 60);
      bx = CW'($urandom());
      by = CW'($urandom());
      bz = CW'($urandom());
      for (int i = 0; i < len; i++) begin
        send_vertex(pick_coord(bx), pick_coord(by), pick_coord(bz), i == len - 1);
      end
      if (!paused && n_sent >= N_RANDOM / 2) begin
        push = 1'b0;
        wait_drained();
        paused = 1'b1;
      end
    end

    push = 1'b0;
    wait_drained();
    repeat (40) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
